[src/stod_pkg.sv]
// shared types and constants for the settable time-of-day clock
// no dependencies; imported by every module of the block

package stod_pkg;

   localparam int TPS_W   = 10;
   localparam int HOLD_W  = 8;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int DCNT_W  = 3;
   localparam int DIGIT_W = 4;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_TICKS_PER_SECOND = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_TICKS       = 1'd1;

   localparam logic [TPS_W-1:0]  TPS_RESET  = 10'd10;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd31;

   localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd12;
   localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
   localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
   localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
   localparam logic [HOLD_W-1:0] HOLD_MAX   = 8'd255;
   localparam logic [DCNT_W-1:0] DIGITS_ALL = 3'd4;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // digit positions while keying in HH:MM
   localparam logic [DCNT_W-1:0] POS_HOUR_TENS = 3'd1;
   localparam logic [DCNT_W-1:0] POS_HOUR_ONES = 3'd2;
   localparam logic [DCNT_W-1:0] POS_MIN_TENS  = 3'd3;

   typedef struct packed {
      logic               tick;
      logic               set_button;
      logic               confirm_button;
      logic               cancel_button;
      logic               key_valid;
      logic [DIGIT_W-1:0] key_digit;
   } item_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
      logic [TPS_W-1:0]  subtick;
      logic [HOLD_W-1:0] hold_count;
      logic [HOUR_W-1:0] saved_hour;
      logic [MIN_W-1:0]  saved_minute;
      logic              entry_flag;
      logic              setting_flag;
      logic [DCNT_W-1:0] digit_count;
   } state_type;

   function automatic logic [HOUR_W-1:0] hour_inc(input logic [HOUR_W-1:0] h);
      hour_inc = (h == HOUR_LAST) ? '0 : h + 5'd1;
   endfunction

endpackage

[src/stod_clock_adv.sv]
// tick prescaler and seconds/minutes/hours ripple
// depends on stod_pkg

module stod_clock_adv
   import stod_pkg::*;
(
   input  state_type        state_cur,
   input  logic             tick,
   input  logic [TPS_W-1:0] ticks_per_second,
   output state_type        state_adv
);

   logic [TPS_W:0] sub_inc;

   always_comb begin
      state_adv = state_cur;
      sub_inc   = {1'b0, state_cur.subtick} + {{TPS_W{1'b0}}, 1'b1};
      if (tick) begin
         if (sub_inc >= {1'b0, ticks_per_second}) begin
            state_adv.subtick = '0;
            if (state_cur.second == SEC_LAST) begin
               state_adv.second = '0;
               if (state_cur.minute == MIN_LAST) begin
                  state_adv.minute = '0;
                  state_adv.hour   = hour_inc(state_cur.hour);
               end else begin
                  state_adv.minute = state_cur.minute + 6'd1;
               end
            end else begin
               state_adv.second = state_cur.second + 6'd1;
            end
         end else begin
            state_adv.subtick = sub_inc[TPS_W-1:0];
         end
      end
   end

endmodule

[src/stod_entry.sv]
// set-button hold detect and keypad time entry
// depends on stod_pkg

module stod_entry
   import stod_pkg::*;
(
   input  state_type         state_adv,
   input  item_type          item,
   input  logic [HOLD_W-1:0] hold_ticks,
   output state_type         state_nxt
);

   state_type         st;
   logic [DCNT_W-1:0] cnt_inc;
   logic [5:0]        hour_sum;
   logic [DIGIT_W-1:0] tens;
   logic [MIN_W-1:0]  min_tens;
   logic [MIN_W:0]    min_sum;
   logic              take;

   always_comb begin
      st       = state_adv;
      cnt_inc  = '0;
      hour_sum = '0;
      tens     = '0;
      min_tens = '0;
      min_sum  = '0;
      take     = 1'b0;

      // hold detect
      if (item.set_button) begin
         if (item.tick) begin
            if (st.hold_count != HOLD_MAX) begin
               st.hold_count = st.hold_count + 8'd1;
            end
            if (st.hold_count == hold_ticks) begin
               st.saved_hour   = st.hour;
               st.saved_minute = st.minute;
               st.entry_flag   = 1'b1;
               st.setting_flag = 1'b1;
               st.digit_count  = '0;
            end
         end
      end else begin
         st.hold_count = '0;
      end

      // keypad entry
      if (st.entry_flag) begin
         if (item.cancel_button) begin
            st.hour         = st.saved_hour;
            st.minute       = st.saved_minute;
            st.entry_flag   = 1'b0;
            st.setting_flag = 1'b0;
         end else if (st.digit_count == '0) begin
            st.hour   = '0;
            st.minute = '0;
         end

         take = st.entry_flag && item.key_valid && (item.key_digit <= DIGIT_MAX)
                && (st.digit_count < DIGITS_ALL);
         if (take) begin
            cnt_inc        = st.digit_count + 3'd1;
            st.digit_count = cnt_inc;
            case (cnt_inc)
               POS_HOUR_TENS: begin
                  st.hour = item.key_digit[0] ? 5'd10 : 5'd0;
               end
               POS_HOUR_ONES: begin
                  hour_sum = {1'b0, st.hour} + {2'b00, item.key_digit};
                  if (hour_sum >= 6'd24) begin
                     hour_sum = hour_sum - 6'd24;
                  end
                  st.hour = hour_sum[HOUR_W-1:0];
               end
               POS_MIN_TENS: begin
                  tens = item.key_digit;
                  // tens above six fold back and carry one hour
                  if (tens > 4'd6) begin
                     tens    = tens - 4'd6;
                     st.hour = hour_inc(st.hour);
                  end
                  min_tens = {2'b00, tens};
                  min_tens = (min_tens << 3) + (min_tens << 1);
                  // tens of six reads as sixty: wrap with an hour carry
                  if (min_tens == 6'd60) begin
                     min_tens = '0;
                     st.hour  = hour_inc(st.hour);
                  end
                  st.minute = min_tens;
               end
               default: begin
                  min_sum = {1'b0, st.minute} + {3'b000, item.key_digit};
                  if (min_sum >= 7'd60) begin
                     min_sum = min_sum - 7'd60;
                     st.hour = hour_inc(st.hour);
                  end
                  st.minute = min_sum[MIN_W-1:0];
               end
            endcase
         end

         if (item.confirm_button && (st.digit_count == DIGITS_ALL)) begin
            st.entry_flag   = 1'b0;
            st.setting_flag = 1'b0;
         end
      end

      state_nxt = st;
   end

endmodule

[src/settable_time_of_day_clock.sv]
// top level of the settable 24-hour time-of-day clock
// depends on stod_pkg, stod_clock_adv and stod_entry
//
//  channel   dir  ports                          payload
//  req       in   req_tvalid/req_tready/tdata    tick, buttons, keypad digit
//  rsp       out  rsp_tvalid/rsp_tready/tdata    hh:mm:ss, setting, entry, digits
//  csr       in   csr_we/csr_addr/csr_wdata      0 ticks_per_second, 1 hold_ticks
//
// one transaction per cycle sustained while rsp_tready holds high; a req goes
// through the input register, then the state update lands with the result register
// the rate rests on the state update loop: clock advance, hold detect and digit
// entry all read the state register and form its next value combinationally
// reset is synchronous, active high; the clock comes up at 12:00:00
// a stalled rsp holds the result and the state; req keeps flowing into the
// input register until it is full as well

module settable_time_of_day_clock
   import stod_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] tick, [1] set_button, [2] confirm_button, [3] cancel_button,
   // [4] key_valid, [8:5] key_digit, [15:9] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] hours, [10:5] minutes, [16:11] seconds, [17] setting,
   // [18] entry_active, [21:19] digits_entered, [23:22] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [TPS_W-1:0]  tps_ff;
   logic [HOLD_W-1:0] hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= TPS_RESET;
         hold_ticks_ff <= HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TICKS_PER_SECOND: tps_ff        <= csr_wdata[TPS_W-1:0];
            CSR_HOLD_TICKS:       hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic     in_valid_ff;
   item_type item_ff;
   logic     advance;
   logic     rsp_valid_ff;
   logic     load_in;

   // the update stage fires when an item waits and the result slot is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign load_in    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         item_ff.tick           <= req_tdata[0];
         item_ff.set_button     <= req_tdata[1];
         item_ff.confirm_button <= req_tdata[2];
         item_ff.cancel_button  <= req_tdata[3];
         item_ff.key_valid      <= req_tdata[4];
         item_ff.key_digit      <= req_tdata[8:5];
      end
   end

   // clock state and its update
   state_type state_ff;
   state_type state_adv;
   state_type state_in;

   stod_clock_adv u_clock_adv (
      .state_cur        (state_ff),
      .tick             (item_ff.tick),
      .ticks_per_second (tps_ff),
      .state_adv        (state_adv)
   );

   stod_entry u_entry (
      .state_adv  (state_adv),
      .item       (item_ff),
      .hold_ticks (hold_ticks_ff),
      .state_nxt  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hour         <= HOUR_RESET;
         state_ff.minute       <= '0;
         state_ff.second       <= '0;
         state_ff.subtick      <= '0;
         state_ff.hold_count   <= '0;
         state_ff.saved_hour   <= '0;
         state_ff.saved_minute <= '0;
         state_ff.entry_flag   <= 1'b0;
         state_ff.setting_flag <= 1'b0;
         state_ff.digit_count  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register, loaded with the same update as the state
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, state_in.digit_count, state_in.entry_flag,
                         state_in.setting_flag, state_in.second,
                         state_in.minute, state_in.hour};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks on the update loop
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.hour <= HOUR_LAST) && (state_ff.minute <= MIN_LAST)
      && (state_ff.second <= SEC_LAST))
      else $error("time of day out of range");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.digit_count <= DIGITS_ALL)
      else $error("digit count past four");

   a_flags_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17] == rsp_tdata[18]))
      else $error("setting and entry flags disagree");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

endmodule
